FILE: design/imf_pkg.sv
// Shared types, constants and helpers for the impulse noise median filter.
// Self-contained; imported by every module of the block but imf_ram.
`default_nettype none

package imf_pkg;

	localparam int MaxWidth  = 2048;
	localparam int MaxHeight = 2048;
	localparam int Radius    = 1;
	localparam int Win       = 2 * Radius + 1;
	localparam int WinN      = Win * Win;
	localparam int Center    = WinN / 2;
	localparam int MinPos    = 2 * Radius;
	localparam int PixW      = 8;
	localparam logic [PixW-1:0] NoiseHi = 8'd255;
	localparam logic [PixW-1:0] NoiseLo = 8'd0;

	localparam int CfgW    = 12;
	localparam int CfgIdxW = 2;
	localparam logic [CfgW-1:0] WidthReset  = 12'd640;
	localparam logic [CfgW-1:0] HeightReset = 12'd480;

	localparam int AddrW = $clog2(MaxWidth);
	localparam int RowW  = $clog2(MaxHeight);
	localparam int WDimW = (CfgW > AddrW + 1) ? CfgW : AddrW + 1;
	localparam int HDimW = (CfgW > RowW + 1) ? CfgW : RowW + 1;

	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QLvlW  = $clog2(QDepth + 1);
	localparam int ODepth = 4;
	localparam int OPtrW  = $clog2(ODepth);
	localparam int OLvlW  = $clog2(ODepth + 1);
	localparam int CntW   = $clog2(WinN + 1);

	typedef enum logic [CfgIdxW-1:0] {
		CFG_IMAGE_WIDTH  = 2'd0,
		CFG_IMAGE_HEIGHT = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [PixW-1:0] pixel_value;
		logic            frame_start;
	} in_item_t;

	typedef struct packed {
		logic [PixW-1:0] filtered_pixel;
		logic            frame_end;
	} out_item_t;

	// one complete window, row-major, plus the end-of-frame mark
	typedef struct packed {
		logic [WinN-1:0][PixW-1:0] pix;
		logic                      frame_end;
	} win_item_t;

	function automatic logic is_noise(input logic [PixW-1:0] v);
		return (v == NoiseLo) || (v == NoiseHi);
	endfunction

endpackage

`default_nettype wire

FILE: design/imf_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Read returns the old word when read and write hit the same address.
`default_nettype none

module imf_ram #(
	parameter int Width = 8,
	parameter int Depth = 2048
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(Depth)-1:0] waddr,
	input  wire  [Width-1:0]         wdata,
	input  wire  [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: design/imf_queue.sv
// Short window queue between the front (window build) and the back (median).
// Depends on imf_pkg for the window item type and depth.
`default_nettype none

module imf_queue (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      push,
	input  wire imf_pkg::win_item_t  push_item,
	input  wire                      pop,
	output imf_pkg::win_item_t       pop_item,
	output logic                     empty,
	output logic [imf_pkg::QLvlW-1:0] level
);
	import imf_pkg::*;

	win_item_t        slot_q [QDepth];
	logic [QPtrW-1:0] wp_q;
	logic [QPtrW-1:0] rp_q;
	logic [QLvlW-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + QPtrW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + QPtrW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QLvlW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QLvlW'(1);
			end
		end
	end

	assign pop_item = slot_q[rp_q];
	assign empty    = (cnt_q == '0);
	assign level    = cnt_q;

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> cnt_q != QLvlW'(QDepth))
		else $error("window queue overflow");
`endif

endmodule

`default_nettype wire

FILE: design/imf_front.sv
// Front: position tracking, line buffers, 3x3 window and border classification.
// Depends on imf_pkg and imf_ram; feeds complete interior windows to imf_queue.
`default_nettype none

module imf_front (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_valid,
	input  wire  [imf_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire  [imf_pkg::CfgW-1:0]     cfg_data,
	input  wire                          push,
	input  wire imf_pkg::in_item_t       item,
	output logic                         full,
	output logic                         q_push,
	output imf_pkg::win_item_t           q_item,
	input  wire  [imf_pkg::QLvlW-1:0]    q_level
);
	import imf_pkg::*;

	logic [CfgW-1:0]  width_q;
	logic [CfgW-1:0]  height_q;
	logic [AddrW-1:0] col_q;
	logic [RowW-1:0]  row_q;
	logic [WinN-1:0][PixW-1:0] win_q;

	logic             v_s1;
	logic             emit_s1;
	logic             fend_s1;
	logic             byp_s1;
	logic [PixW-1:0]  bypd_s1;
	logic [AddrW-1:0] c_s1;
	logic [PixW-1:0]  pix_s1;

	logic             accept;
	logic [WDimW-1:0] w_eff;
	logic [HDimW-1:0] h_eff;
	logic [AddrW-1:0] c0;
	logic [AddrW-1:0] cur_col;
	logic [RowW-1:0]  cur_row;
	logic [HDimW-1:0] r1;
	logic             wrap_c;
	logic [WDimW-1:0] c_inc;
	logic [HDimW-1:0] r_inc;
	logic [AddrW-1:0] col_nx;
	logic [RowW-1:0]  row_nx;
	logic             emit;
	logic             fend;
	logic [PixW-1:0]  mid_rd;
	logic [PixW-1:0]  top_rd;
	logic [PixW-1:0]  top_val;
	logic [WinN-1:0][PixW-1:0] win_nx;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WidthReset;
			height_q <= HeightReset;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_IMAGE_WIDTH:  width_q  <= cfg_data;
				CFG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// size in use, clamped to the legal range
	always_comb begin
		if (WDimW'(width_q) < WDimW'(3)) begin
			w_eff = WDimW'(3);
		end else if (WDimW'(width_q) > WDimW'(MaxWidth)) begin
			w_eff = WDimW'(MaxWidth);
		end else begin
			w_eff = WDimW'(width_q);
		end
		if (HDimW'(height_q) < HDimW'(3)) begin
			h_eff = HDimW'(3);
		end else if (HDimW'(height_q) > HDimW'(MaxHeight)) begin
			h_eff = HDimW'(MaxHeight);
		end else begin
			h_eff = HDimW'(height_q);
		end
	end

	// hold back input while the queue could not take this pixel's window
	assign full   = (QLvlW'(q_level) + QLvlW'(v_s1 && emit_s1)) >= QLvlW'(QDepth);
	assign accept = push && !full;

	// position of the incoming pixel, after frame start and stale-size wrap
	always_comb begin
		c0      = item.frame_start ? '0 : col_q;
		wrap_c  = WDimW'(c0) >= w_eff;
		r1      = item.frame_start ? '0 : HDimW'(row_q);
		if (wrap_c) begin
			r1 = r1 + HDimW'(1);
		end
		if (r1 >= h_eff) begin
			r1 = '0;
		end
		cur_col = wrap_c ? '0 : c0;
		cur_row = r1[RowW-1:0];
		c_inc   = WDimW'(cur_col) + WDimW'(1);
		r_inc   = HDimW'(cur_row) + HDimW'(1);
		if (c_inc >= w_eff) begin
			col_nx = '0;
			row_nx = (r_inc >= h_eff) ? '0 : r_inc[RowW-1:0];
		end else begin
			col_nx = c_inc[AddrW-1:0];
			row_nx = cur_row;
		end
		emit = (cur_col >= AddrW'(MinPos)) && (cur_row >= RowW'(MinPos));
		fend = (WDimW'(cur_col) == w_eff - WDimW'(1))
			&& (HDimW'(cur_row) == h_eff - HDimW'(1));
	end

	// newest row buffer: written with the pixel on accept, old word read out
	imf_ram #(.Width(PixW), .Depth(MaxWidth)) u_mid_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (cur_col),
		.wdata (item.pixel_value),
		.raddr (cur_col),
		.rdata (mid_rd)
	);

	// older row buffer: takes the displaced newest-row word in the next cycle
	imf_ram #(.Width(PixW), .Depth(MaxWidth)) u_top_ram (
		.clk   (clk),
		.we    (v_s1),
		.waddr (c_s1),
		.wdata (mid_rd),
		.raddr (cur_col),
		.rdata (top_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			v_s1    <= 1'b0;
			emit_s1 <= 1'b0;
			byp_s1  <= 1'b0;
		end else begin
			v_s1 <= accept;
			if (accept) begin
				col_q   <= col_nx;
				row_q   <= row_nx;
				emit_s1 <= emit;
				// same column read while its older-row write is still pending
				byp_s1  <= v_s1 && (cur_col == c_s1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			c_s1    <= cur_col;
			pix_s1  <= item.pixel_value;
			fend_s1 <= fend;
			bypd_s1 <= mid_rd;
		end
	end

	assign top_val = byp_s1 ? bypd_s1 : top_rd;

	always_comb begin
		for (int r = 0; r < Win; r++) begin
			for (int k = 0; k < Win - 1; k++) begin
				win_nx[r * Win + k] = win_q[r * Win + k + 1];
			end
		end
		win_nx[Win - 1]           = top_val;
		win_nx[2 * Win - 1]       = mid_rd;
		win_nx[Win * Win - 1]     = pix_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (v_s1) begin
			win_q <= win_nx;
		end
	end

	assign q_push           = v_s1 && emit_s1;
	assign q_item.pix       = win_nx;
	assign q_item.frame_end = fend_s1;

`ifndef ASSERT_OFF
	a_col_moves: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> col_q != $past(cur_col))
		else $error("column position did not advance");
`endif

endmodule

`default_nettype wire

FILE: design/imf_back.sv
// Back: switching median over one window and the result queue.
// Depends on imf_pkg; pulls windows from imf_queue.
`default_nettype none

module imf_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 q_empty,
	input  wire imf_pkg::win_item_t q_item,
	output logic                q_pop,
	input  wire                 pop,
	output logic                empty,
	output imf_pkg::out_item_t  result
);
	import imf_pkg::*;

	logic                      v_s1;
	logic [WinN-1:0][PixW-1:0] pix_s1;
	logic [WinN-1:0]           vld_s1;
	logic [WinN-1:0][WinN-1:0] below_s1;
	logic                      fend_s1;

	logic [WinN-1:0]           vld;
	logic [WinN-1:0][WinN-1:0] below;
	logic [CntW-1:0]           n_vld;
	logic [PixW-1:0]           med;
	logic [PixW-1:0]           centre;
	out_item_t                 res;

	out_item_t        oq_q [ODepth];
	logic [OPtrW-1:0] wp_q;
	logic [OPtrW-1:0] rp_q;
	logic [OLvlW-1:0] ocnt_q;
	logic             out_pop;

	// take a window only when the result queue has room for everything in flight
	assign q_pop = !q_empty
		&& ((OLvlW'(ocnt_q) + OLvlW'(v_s1)) < OLvlW'(ODepth));

	// pairwise order among clean values; equal values break ties by position
	always_comb begin
		for (int i = 0; i < WinN; i++) begin
			vld[i] = !is_noise(q_item.pix[i]);
		end
		for (int i = 0; i < WinN; i++) begin
			for (int j = 0; j < WinN; j++) begin
				below[i][j] = vld[j] && ((q_item.pix[j] < q_item.pix[i])
					|| ((q_item.pix[j] == q_item.pix[i]) && (j < i)));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= q_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			pix_s1   <= q_item.pix;
			vld_s1   <= vld;
			below_s1 <= below;
			fend_s1  <= q_item.frame_end;
		end
	end

	// pick the clean value whose rank is half the clean count
	always_comb begin
		n_vld = CntW'($countones(vld_s1));
		med   = '0;
		for (int i = 0; i < WinN; i++) begin
			if (vld_s1[i] && (CntW'($countones(below_s1[i])) == (n_vld >> 1))) begin
				med = med | pix_s1[i];
			end
		end
		centre = pix_s1[Center];
		res.filtered_pixel = (!is_noise(centre) || (n_vld == '0)) ? centre : med;
		res.frame_end      = fend_s1;
	end

	assign out_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (v_s1) begin
			oq_q[wp_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			ocnt_q <= '0;
		end else begin
			if (v_s1) begin
				wp_q <= wp_q + OPtrW'(1);
			end
			if (out_pop) begin
				rp_q <= rp_q + OPtrW'(1);
			end
			if (v_s1 && !out_pop) begin
				ocnt_q <= ocnt_q + OLvlW'(1);
			end else if (out_pop && !v_s1) begin
				ocnt_q <= ocnt_q - OLvlW'(1);
			end
		end
	end

	assign empty  = (ocnt_q == '0);
	assign result = oq_q[rp_q];

`ifndef ASSERT_OFF
	a_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !out_pop |-> ocnt_q != OLvlW'(ODepth))
		else $error("result queue overflow");
`endif

endmodule

`default_nettype wire

FILE: design/impulse_noise_median_filter.sv
// Top level of the switching 3x3 median filter for salt-and-pepper noise.
// Depends on imf_pkg, imf_front, imf_queue and imf_back.
//
//   channel   handshake              payload            direction
//   config    cfg_valid / cfg_ready  cfg_index,cfg_data in
//   pixels    push / full            item               in
//   results   pop / empty            result             out
//
// One pixel per clock while full is low; a result follows its completing
// pixel through the registered line-buffer read, the window queue write
// and one median stage. No clearing pass after reset: line buffers are
// valid once two rows of a frame have passed. full rises only when the
// window queue cannot absorb the pixel in flight; results wait in a
// four-deep queue.
`default_nettype none

module impulse_noise_median_filter (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [imf_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire  [imf_pkg::CfgW-1:0]     cfg_data,
	input  wire                          push,
	output logic                         full,
	input  wire imf_pkg::in_item_t       item,
	output logic                         empty,
	input  wire                          pop,
	output imf_pkg::out_item_t           result
);
	import imf_pkg::*;

	logic             q_push;
	win_item_t        q_in;
	logic             q_pop;
	win_item_t        q_out;
	logic             q_empty;
	logic [QLvlW-1:0] q_level;

	assign cfg_ready = 1'b1;

	imf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.item      (item),
		.full      (full),
		.q_push    (q_push),
		.q_item    (q_in),
		.q_level   (q_level)
	);

	imf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in),
		.pop       (q_pop),
		.pop_item  (q_out),
		.empty     (q_empty),
		.level     (q_level)
	);

	imf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_item  (q_out),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

`ifndef ASSERT_OFF
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("window queue read while empty");
`endif

endmodule

`default_nettype wire

FILE: bench/impulse_noise_median_filter_test.sv
// Self-checking bench for impulse_noise_median_filter: random pixel frames, short frames,
// size changes and queue-side stalls, each result checked against an in-bench filter model.
// Depends on imf_pkg and the impulse_noise_median_filter RTL.

module impulse_noise_median_filter_test;
	import imf_pkg::*;

	localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;  // no register decoded here
	localparam int IdleLimit    = 1000;
	localparam int SettleCycles = 16;
	localparam int RandomPixels = 1700;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgW-1:0]     cfg_data = '0;
	logic                push = 1'b0;
	logic                full;
	in_item_t            item = '0;
	logic                empty;
	logic                pop = 1'b0;
	out_item_t           result;

	impulse_noise_median_filter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// filter model state
	logic [PixW-1:0] prev_row [MaxWidth];
	logic [PixW-1:0] older_row [MaxWidth];
	logic [PixW-1:0] tile [Win][Win];
	int unsigned     col_pos = 0;
	int unsigned     row_pos = 0;
	logic [CfgW-1:0] width_reg = WidthReset;
	logic [CfgW-1:0] height_reg = HeightReset;
	out_item_t       cleaned_due [$];

	// stimulus and handshake state
	in_item_t        pixel_feed [$];
	int unsigned     pixels_queued = 0;
	int unsigned     gen_w = 3;
	int unsigned     gen_h = 3;
	bit              aligned = 1'b1;
	int unsigned     noise_pct = 35;
	bit              pix_moved = 1'b0;
	bit              res_moved = 1'b0;
	int unsigned     pix_wait = 0;
	int unsigned     pop_wait = 0;
	bit              send_burst = 1'b0;
	bit              take_burst = 1'b0;
	int unsigned     idle_cycles = 0;
	int unsigned     err_count = 0;

	function automatic int unsigned clamp_dim(input logic [CfgW-1:0] v, input int unsigned hi);
		if (v < 3) return 3;
		if (v > hi) return hi;
		return 32'(v);
	endfunction

	function automatic bit is_impulse(input logic [PixW-1:0] v);
		return v == NoiseLo || v == NoiseHi;
	endfunction

	function automatic logic [PixW-1:0] repair_centre();
		logic [PixW-1:0] kept [WinN];
		logic [PixW-1:0] v;
		logic [PixW-1:0] ctr;
		int unsigned n;
		int unsigned k;
		int i;
		int j;
		ctr = tile[Radius][Radius];
		if (!is_impulse(ctr)) return ctr;
		n = 0;
		for (i = 0; i < Win; i++) begin
			for (j = 0; j < Win; j++) begin
				v = tile[i][j];
				if (!is_impulse(v)) begin
					k = n;
					while (k > 0 && kept[k-1] > v) begin
						kept[k] = kept[k-1];
						k--;
					end
					kept[k] = v;
					n++;
				end
			end
		end
		if (n == 0) return ctr;
		return kept[n/2];
	endfunction

	task automatic filter_pixel(input in_item_t px);
		int unsigned w;
		int unsigned h;
		int unsigned c;
		int unsigned r;
		logic [PixW-1:0] up;
		logic [PixW-1:0] mid;
		out_item_t res;
		int i;
		w = clamp_dim(width_reg, MaxWidth);
		h = clamp_dim(height_reg, MaxHeight);
		if (px.frame_start) begin
			col_pos = 0;
			row_pos = 0;
		end
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= h) row_pos = 0;
		c = col_pos;
		r = row_pos;
		up = older_row[c];
		mid = prev_row[c];
		for (i = 0; i < Win; i++) begin
			tile[i][0] = tile[i][1];
			tile[i][1] = tile[i][2];
		end
		tile[0][2] = up;
		tile[1][2] = mid;
		tile[2][2] = px.pixel_value;
		older_row[c] = mid;
		prev_row[c] = px.pixel_value;
		if (c >= MinPos && r >= MinPos) begin
			res.filtered_pixel = repair_centre();
			res.frame_end = (c == w - 1 && r == h - 1);
			cleaned_due.push_back(res);
		end
		col_pos = c + 1;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos = r + 1;
			if (row_pos >= h) row_pos = 0;
		end
	endtask

	// sample every transfer at the rising edge
	always @(posedge clk) begin
		out_item_t want;
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				moved = 1'b1;
				case (cfg_reg_t'(cfg_index))
					CFG_IMAGE_WIDTH: width_reg = cfg_data;
					CFG_IMAGE_HEIGHT: height_reg = cfg_data;
					default: ;
				endcase
			end
			if (push && !full) begin
				moved = 1'b1;
				pix_moved = 1'b1;
				filter_pixel(item);
			end
			if (pop && !empty) begin
				moved = 1'b1;
				res_moved = 1'b1;
				if (cleaned_due.size() == 0) begin
					err_count++;
					$display("%0t: result with none pending: expected nothing, actual %0d/%0b",
						$time, result.filtered_pixel, result.frame_end);
				end else begin
					want = cleaned_due.pop_front();
					if (result.filtered_pixel !== want.filtered_pixel) begin
						err_count++;
						$display("%0t: filtered_pixel expected %0d, actual %0d",
							$time, want.filtered_pixel, result.filtered_pixel);
					end
					if (result.frame_end !== want.frame_end) begin
						err_count++;
						$display("%0t: frame_end expected %0b, actual %0b",
							$time, want.frame_end, result.frame_end);
					end
				end
			end
			if (moved) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IdleLimit) begin
				$display("watchdog: %0d cycles without a transfer at %0t", idle_cycles, $time);
				$display("FAIL impulse_noise_median_filter");
				$finish;
			end
		end
	end

	// pixel side: hold push until the transfer, then wait the drawn gap
	always @(negedge clk) begin
		logic nxt;
		nxt = push;
		if (pix_moved) begin
			pix_moved = 1'b0;
			nxt = 1'b0;
			pix_wait = send_burst ? 0 : $urandom_range(0, 6);
			if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
		end
		if (!nxt && arst_n) begin
			if (pix_wait > 0) pix_wait--;
			else if (pixel_feed.size() != 0) begin
				item <= pixel_feed.pop_front();
				nxt = 1'b1;
			end
		end
		push <= nxt;
	end

	// result side: drop pop for the drawn stall after each transfer
	always @(negedge clk) begin
		logic nxt;
		nxt = pop;
		if (res_moved) begin
			res_moved = 1'b0;
			nxt = 1'b0;
			pop_wait = take_burst ? 0 : $urandom_range(0, 6);
			if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
		end
		if (!nxt) begin
			if (pop_wait > 0) pop_wait--;
			else nxt = 1'b1;
		end
		pop <= nxt;
	end

	task automatic wait_idle();
		do @(posedge clk);
		while (pixel_feed.size() != 0 || push || cleaned_due.size() != 0);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_geometry(input logic [CfgW-1:0] w_raw, input logic [CfgW-1:0] h_raw);
		wait_idle();
		write_reg(CFG_IMAGE_WIDTH, w_raw);
		write_reg(CFG_IMAGE_HEIGHT, h_raw);
		gen_w = clamp_dim(w_raw, MaxWidth);
		gen_h = clamp_dim(h_raw, MaxHeight);
	endtask

	task automatic queue_pixel(input logic [PixW-1:0] v, input logic fs);
		in_item_t px;
		px.pixel_value = v;
		px.frame_start = fs;
		pixel_feed.push_back(px);
		pixels_queued++;
	endtask

	function automatic logic [PixW-1:0] draw_pixel();
		if ($urandom_range(0, 99) < noise_pct) return $urandom_range(0, 1) ? NoiseHi : NoiseLo;
		return PixW'($urandom_range(0, 255));
	endfunction

	function automatic logic [CfgW-1:0] pick_dim(input int unsigned top);
		case ($urandom_range(0, 9))
			0: return CfgW'($urandom_range(0, 2));
			1: return CfgW'($urandom_range(top + 1, 2 * top + 6));
			default: return CfgW'($urandom_range(3, top));
		endcase
	endfunction

	// a frame may skip frame_start only when the positions are known to be at the origin
	task automatic queue_frame(input int unsigned n);
		logic fs;
		int unsigned i;
		fs = aligned ? ($urandom_range(0, 3) != 0) : 1'b1;
		case ($urandom_range(0, 3))
			0: noise_pct = 5;
			1: noise_pct = 35;
			2: noise_pct = 70;
			default: noise_pct = 95;
		endcase
		for (i = 0; i < n; i++) queue_pixel(draw_pixel(), i == 0 ? fs : 1'b0);
		aligned = (n == gen_w * gen_h);
	endtask

	// change the geometry (never growing the width) in the middle of a frame, then carry on
	task automatic break_frame(input logic [CfgW-1:0] w_raw, input logic [CfgW-1:0] h_raw,
			input int unsigned tail);
		int unsigned i;
		set_geometry(w_raw, h_raw);
		for (i = 0; i < tail; i++) queue_pixel(draw_pixel(), 1'b0);
		aligned = 1'b0;
	endtask

	initial begin
		logic [PixW-1:0] pat5 [15] = '{
			8'd0,   8'd255, 8'd0,   8'd10, 8'd254,
			8'd255, 8'd0,   8'd255, 8'd128, 8'd1,
			8'd0,   8'd255, 8'd0,   8'd0,  8'd200};
		logic [PixW-1:0] pat3 [9] = '{
			8'd1,   8'd100, 8'd254,
			8'd255, 8'd255, 8'd7,
			8'd9,   8'd0,   8'd255};
		int unsigned i;
		int unsigned start_count;
		int unsigned sel;
		for (i = 0; i < MaxWidth; i++) begin
			prev_row[i] = '0;
			older_row[i] = '0;
		end
		for (i = 0; i < Win * Win; i++) tile[i / Win][i % Win] = '0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// all-impulse window, even count (upper median), passthrough; height clamps up to 3
		set_geometry(12'd5, 12'd2);
		for (i = 0; i < 15; i++) queue_pixel(pat5[i], i == 0);
		wait_idle();
		write_reg(CfgSpare, 12'hFFF);
		// width clamps up to 3; the frame follows by wrap, no frame_start
		set_geometry(12'd1, 12'd3);
		for (i = 0; i < 9; i++) queue_pixel(pat3[i], 1'b0);
		aligned = 1'b1;

		// start of the widest row, then a mid-frame shrink that wraps the column
		set_geometry(12'd2048, 12'd3);
		queue_frame(40);
		break_frame(12'd6, 12'd3, 30);
		// tallest frame (clamped), then a height shrink that wraps the row
		set_geometry(12'd3, 12'hFFF);
		queue_frame(60);
		break_frame(12'd3, 12'd5, 20);

		start_count = pixels_queued;
		while (pixels_queued - start_count < RandomPixels) begin
			set_geometry(pick_dim(10), pick_dim(6));
			repeat ($urandom_range(1, 3)) begin
				sel = $urandom_range(0, 9);
				if (sel < 7) queue_frame(gen_w * gen_h);
				else if (sel < 9) queue_frame($urandom_range(1, gen_w * gen_h - 1));
				else begin
					queue_frame($urandom_range(1, gen_w * gen_h - 1));
					break_frame(CfgW'($urandom_range(0, gen_w)), CfgW'($urandom_range(0, 8)),
						$urandom_range(1, 3 * gen_w));
				end
			end
		end

		wait_idle();
		if (err_count == 0) begin
			$display("PASS impulse_noise_median_filter");
		end else begin
			$display("FAIL impulse_noise_median_filter");
		end
		$finish;
	end

endmodule
